FILE: hw/rtl/tcdf_pkg.sv
// ----------------------------------------------------------------------------
// tcdf_pkg
// Types and constants shared by the triangular CDF block.
// ----------------------------------------------------------------------------
package tcdf_pkg;

    localparam int DATA_W   = 32;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int POS_W    = $clog2(PROD_W);
    localparam int FRAC_W   = 30;
    localparam int LOG_FRAC = 24;
    localparam int MANT_W   = 32;
    localparam int LOGV_W   = POS_W + LOG_FRAC;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] LOG_NEG = 32'h8000_0000;

    localparam logic [1:0] REG_LOWER_TAIL = 2'd0;
    localparam logic [1:0] REG_LOG_OUT    = 2'd1;

    typedef enum logic [2:0] {
        CLS_INV,
        CLS_ZERO,
        CLS_RISE,
        CLS_FALL,
        CLS_ONE
    } t_cls;

    typedef struct packed {
        logic signed [DATA_W-1:0] quantile;
        logic signed [DATA_W-1:0] lower_bound;
        logic signed [DATA_W-1:0] upper_bound;
        logic signed [DATA_W-1:0] peak;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic               invalid;
        logic               minus_infinity;
    } t_out_word;

    typedef struct packed {
        t_cls              cls;
        logic [DATA_W-1:0] delta;
        logic [DATA_W-1:0] span1;
        logic [DATA_W-1:0] span2;
    } t_cmd;

    typedef struct packed {
        logic left_tail;
        logic log_out;
    } t_cfg;

    function automatic logic [POS_W-1:0] lead_pos(input logic [PROD_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (x[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [MANT_W-1:0] norm_mant(input logic [PROD_W-1:0] x,
                                                   input logic [POS_W-1:0] e);
        logic [PROD_W-1:0] s;
        s = x << (POS_W'(PROD_W - 1) - e);
        return s[PROD_W-1 -: MANT_W];
    endfunction

endpackage

FILE: hw/rtl/tcdf_front.sv
// ----------------------------------------------------------------------------
// tcdf_front
// Checks the bounds, picks the side of the peak and forms the distances.
// ----------------------------------------------------------------------------
module tcdf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tcdf_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output tcdf_pkg::t_cmd    o_cmd
);
    import tcdf_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic signed [DATA_W:0] w_q, w_a, w_b, w_c;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        w_q = {i_word.quantile[DATA_W-1], i_word.quantile};
        w_a = {i_word.lower_bound[DATA_W-1], i_word.lower_bound};
        w_b = {i_word.upper_bound[DATA_W-1], i_word.upper_bound};
        w_c = {i_word.peak[DATA_W-1], i_word.peak};
        n_cmd.span1 = DATA_W'(w_b - w_a);
        n_cmd.delta = '0;
        n_cmd.span2 = '0;
        priority if (w_a >= w_b || w_c > w_b || w_a > w_c) begin
            n_cmd.cls = CLS_INV;
        end else if (w_q <= w_a) begin
            n_cmd.cls = CLS_ZERO;
        end else if (w_q <= w_c) begin
            n_cmd.cls   = CLS_RISE;
            n_cmd.delta = DATA_W'(w_q - w_a);
            n_cmd.span2 = DATA_W'(w_c - w_a);
        end else if (w_q < w_b) begin
            n_cmd.cls   = CLS_FALL;
            n_cmd.delta = DATA_W'(w_b - w_q);
            n_cmd.span2 = DATA_W'(w_b - w_c);
        end else begin
            n_cmd.cls = CLS_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: hw/rtl/tcdf_queue.sv
// ----------------------------------------------------------------------------
// tcdf_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module tcdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  tcdf_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_pop,
    output tcdf_pkg::t_cmd o_cmd
);
    import tcdf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/tcdf_back.sv
// ----------------------------------------------------------------------------
// tcdf_back
// Products, ratio by restoring division and log2 by repeated squaring,
// all pipelined, with the result register at the end.
// ----------------------------------------------------------------------------
module tcdf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcdf_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  tcdf_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output tcdf_pkg::t_out_word o_word
);
    import tcdf_pkg::*;

    typedef struct packed {
        logic              v;
        t_cls              cls;
        logic [PROD_W-1:0] sq;
        logic [PROD_W-1:0] dd;
    } t_s1;

    typedef struct packed {
        logic              v;
        logic              inv;
        logic [PROD_W-1:0] n;
        logic [PROD_W-1:0] d;
    } t_s2;

    typedef struct packed {
        logic                v;
        logic                inv;
        logic                nz;
        logic                eq;
        logic [PROD_W:0]     n;
        logic [PROD_W-1:0]   d;
        logic [FRAC_W-1:0]   q;
        logic [MANT_W-1:0]   mn;
        logic [MANT_W-1:0]   md;
        logic [LOG_FRAC-1:0] fn;
        logic [LOG_FRAC-1:0] fd;
        logic [POS_W-1:0]    en;
        logic [POS_W-1:0]    ed;
    } t_st;

    typedef struct packed {
        logic                     v;
        logic                     inv;
        logic                     nz;
        logic                     eq;
        logic [FRAC_W-1:0]        q;
        logic [LOGV_W+30-1:0]     prod;
    } t_s4;

    logic      w_en;
    t_s1       r_s1;
    t_s2       r_s2;
    t_s2       n_s2;
    t_st       r_st [FRAC_W+1];
    t_s4       r_s4;
    logic      r_ov;
    t_out_word r_out;
    t_out_word n_out;
    logic [LOGV_W-1:0] w_mag;
    logic [LOGV_W+30-1:0] w_rnd;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ov;
    assign o_word  = r_out;

    always_comb begin
        logic [PROD_W-1:0] n0;
        n_s2.v   = r_s1.v;
        n_s2.inv = r_s1.cls == CLS_INV;
        n0       = '0;
        n_s2.d   = PROD_W'(1);
        unique case (r_s1.cls)
            CLS_RISE: begin
                n0     = r_s1.sq;
                n_s2.d = r_s1.dd;
            end
            CLS_FALL: begin
                n0     = r_s1.dd - r_s1.sq;
                n_s2.d = r_s1.dd;
            end
            CLS_ONE:  n0 = PROD_W'(1);
            default:  n0 = '0;
        endcase
        n_s2.n = i_cfg.left_tail ? n0 : n_s2.d - n0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
            r_s2.v <= 1'b0;
            r_st[0].v <= 1'b0;
        end else if (w_en) begin
            r_s1.v <= i_valid;
            r_s2.v <= r_s1.v;
            r_st[0].v <= r_s2.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.cls <= i_cmd.cls;
            r_s1.sq  <= i_cmd.delta * i_cmd.delta;
            r_s1.dd  <= i_cmd.span1 * i_cmd.span2;
            r_s2.inv <= n_s2.inv;
            r_s2.n   <= n_s2.n;
            r_s2.d   <= n_s2.d;
            r_st[0].inv <= r_s2.inv;
            r_st[0].nz  <= r_s2.n == '0;
            r_st[0].eq  <= r_s2.n == r_s2.d;
            r_st[0].n   <= {1'b0, r_s2.n};
            r_st[0].d   <= r_s2.d;
            r_st[0].q   <= '0;
            r_st[0].en  <= lead_pos(r_s2.n);
            r_st[0].ed  <= lead_pos(r_s2.d);
            r_st[0].mn  <= norm_mant(r_s2.n, lead_pos(r_s2.n));
            r_st[0].md  <= norm_mant(r_s2.d, lead_pos(r_s2.d));
            r_st[0].fn  <= '0;
            r_st[0].fd  <= '0;
        end
    end

    for (genvar j = 0; j < FRAC_W; j++) begin : g_step
        t_st n_st;

        always_comb begin
            logic [PROD_W:0]     t;
            logic [2*MANT_W-1:0] pn;
            logic [2*MANT_W-1:0] pd;
            n_st = r_st[j];
            t    = {1'b0, r_st[j].d} - r_st[j].n;
            if (r_st[j].n >= t) begin
                n_st.n = r_st[j].n - t;
                n_st.q = {r_st[j].q[FRAC_W-2:0], 1'b1};
            end else begin
                n_st.n = {r_st[j].n[PROD_W-1:0], 1'b0};
                n_st.q = {r_st[j].q[FRAC_W-2:0], 1'b0};
            end
            pn = '0;
            pd = '0;
            if (j < LOG_FRAC) begin
                pn = r_st[j].mn * r_st[j].mn;
                pd = r_st[j].md * r_st[j].md;
                n_st.fn = {r_st[j].fn[LOG_FRAC-2:0], pn[2*MANT_W-1]};
                n_st.fd = {r_st[j].fd[LOG_FRAC-2:0], pd[2*MANT_W-1]};
                n_st.mn = pn[2*MANT_W-1] ? pn[2*MANT_W-1 -: MANT_W]
                                         : pn[2*MANT_W-2 -: MANT_W];
                n_st.md = pd[2*MANT_W-1] ? pd[2*MANT_W-1 -: MANT_W]
                                         : pd[2*MANT_W-2 -: MANT_W];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[j+1].v <= 1'b0;
            end else if (w_en) begin
                r_st[j+1].v <= n_st.v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_st[j+1][$bits(t_st)-2:0] <= n_st[$bits(t_st)-2:0];
            end
        end
    end

    assign w_mag = ({r_st[FRAC_W].ed, r_st[FRAC_W].fd} > {r_st[FRAC_W].en, r_st[FRAC_W].fn})
                 ? {r_st[FRAC_W].ed, r_st[FRAC_W].fd} - {r_st[FRAC_W].en, r_st[FRAC_W].fn}
                 : '0;
    assign w_rnd = r_s4.prod + (LOGV_W+30)'(1 << 29);

    always_comb begin
        logic [31:0] lm;
        lm = 32'(w_rnd >> 30);
        n_out.invalid        = r_s4.inv;
        n_out.minus_infinity = 1'b0;
        n_out.value          = '0;
        priority if (r_s4.inv) begin
            n_out.value = '0;
        end else if (!i_cfg.log_out) begin
            n_out.value = r_s4.eq ? ONE_Q30 : {2'b00, r_s4.q};
        end else if (r_s4.nz) begin
            n_out.value          = LOG_NEG;
            n_out.minus_infinity = 1'b1;
        end else if (r_s4.eq) begin
            n_out.value = '0;
        end else begin
            n_out.value = 32'(0) - lm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (w_en) begin
            r_s4.v <= r_st[FRAC_W].v;
            r_ov   <= r_s4.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4.inv  <= r_st[FRAC_W].inv;
            r_s4.nz   <= r_st[FRAC_W].nz;
            r_s4.eq   <= r_st[FRAC_W].eq;
            r_s4.q    <= r_st[FRAC_W].q;
            r_s4.prod <= w_mag * LN2_Q30;
            r_out     <= n_out;
        end
    end

endmodule

FILE: hw/rtl/triangular_cdf_top.sv
// ----------------------------------------------------------------------------
// triangular_cdf_top
// Triangular distribution CDF, linear Q2.30 or natural log Q8.24.
// ----------------------------------------------------------------------------
// Input words carry quantile, lower bound, upper bound and peak (signed Q16.16)
// on a valid/ready channel; result words carry value, invalid and
// minus_infinity on a second valid/ready channel. Configuration writes use a
// third channel, always ready: index 0 is the lower-tail bit, index 1 the log
// output bit; other indexes are ignored. Write it only while the block is idle.
// Every word gives one result. It passes a classify register, a two-word queue,
// a product stage, a numerator select stage, a normalise stage, 30 divider
// stages (squaring runs in the first LOG_FRAC of them), the log scaling multiply
// and the result register. One word is accepted per cycle while o_in_ready is high.
// When the receiver stalls, the whole arithmetic pipeline holds; the front and
// queue keep taking up to three more words before o_in_ready drops.
// Reset empties the pipeline and sets lower-tail mode on, log output off.
// ----------------------------------------------------------------------------
module triangular_cdf_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcdf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcdf_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import tcdf_pkg::*;

    t_cfg r_cfg;
    logic w_f_valid, w_f_ready, w_q_valid, w_q_pop;
    t_cmd w_f_cmd, w_q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_tail <= 1'b1;
            r_cfg.log_out   <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_LOWER_TAIL) begin
                r_cfg.left_tail <= i_cfg_data[0];
            end
            if (i_cfg_index == REG_LOG_OUT) begin
                r_cfg.log_out <= i_cfg_data[0];
            end
        end
    end

    tcdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cmd   (w_f_cmd)
    );

    tcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .o_ready (w_f_ready),
        .i_cmd   (w_f_cmd),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    tcdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .o_ready (w_q_pop),
        .i_cmd   (w_q_cmd),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.invalid && o_out_word.minus_infinity))
        else $error("invalid and minus_infinity both set");

    a_ninf_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.minus_infinity) |-> r_cfg.log_out)
        else $error("minus_infinity outside log mode");

    a_lin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_cfg.log_out) |-> (o_out_word.value <= $signed(ONE_Q30)))
        else $error("linear probability above one");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.invalid) |-> (o_out_word.value == '0))
        else $error("invalid result with non-zero value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule
